// ===== rtl/bilinear_quad_shape_jacobian_defines.svh =====
// ---------------------------------------------------------------------------
// bilinear_quad_shape_jacobian_defines.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_QUAD_SHAPE_JACOBIAN_DEFINES_SVH
`define BILINEAR_QUAD_SHAPE_JACOBIAN_DEFINES_SVH

// checked only out of reset
`define BQSJ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked during reset as well
`define BQSJ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bqsj_pkg.sv =====
// ---------------------------------------------------------------------------
// bqsj_pkg
// Types, Gauss tables and shape-gradient helpers for the Q4 Jacobian block.
// ---------------------------------------------------------------------------
`default_nettype none

package bqsj_pkg;

  localparam int ONE_Q16 = 65536;
  localparam int QBITS   = 32;   // quotient bits per divide
  localparam int QDEPTH  = 4;    // front-to-back queue depth
  localparam int QPTR_W  = 2;

  typedef logic signed [16:0] abs_t;    // Gauss abscissa, signed Q1.16
  typedef logic signed [17:0] grad_t;   // 4*dN/dr or 4*dN/ds, signed Q2.16
  typedef logic        [16:0] shape_t;  // N, unsigned Q1.16, always positive
  typedef logic        [17:0] wt_t;     // Gauss weight, unsigned Q2.16

  typedef struct packed {
    abs_t                ra;
    abs_t                sa;
    shape_t [3:0]        shape;
    logic signed [31:0]  j00;
    logic signed [31:0]  j01;
    logic signed [31:0]  j10;
    logic signed [31:0]  j11;
    logic                det_neg;
    logic [63:0]         det_mag;
    logic                sing;
    logic signed [31:0]  wout;
  } bqsj_item_t;

  typedef struct packed {
    logic [1:0]          node;
    logic                last;
    shape_t              shape;
    logic signed [31:0]  wout;
    logic                sing;
    logic                neg_x;
    logic                neg_y;
  } bqsj_meta_t;

  // r index = idx mod pts
  function automatic logic [1:0] point_r(input int pts, input logic [1:0] idx);
    logic [1:0] r;
    r = '0;
    unique case (pts)
      2:       r = {1'b0, idx[0]};
      3:       r = (idx == 2'd3) ? 2'd0 : idx;
      4:       r = idx;
      default: r = '0;
    endcase
    return r;
  endfunction

  // s index = (idx div pts) mod pts
  function automatic logic [1:0] point_s(input int pts, input logic [1:0] idx);
    logic [1:0] s;
    s = '0;
    unique case (pts)
      2:       s = {1'b0, idx[1]};
      3:       s = (idx == 2'd3) ? 2'd1 : 2'd0;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic abs_t gauss_abs(input int pts, input logic [1:0] i);
    abs_t a;
    a = '0;
    unique case (pts)
      2: begin
        unique case (i)
          2'd0:    a = -abs_t'(37837);
          2'd1:    a = abs_t'(37837);
          default: a = '0;
        endcase
      end
      3: begin
        unique case (i)
          2'd0:    a = -abs_t'(50765);
          2'd2:    a = abs_t'(50765);
          default: a = '0;
        endcase
      end
      4: begin
        unique case (i)
          2'd0:    a = -abs_t'(56435);
          2'd1:    a = -abs_t'(22281);
          2'd2:    a = abs_t'(22281);
          default: a = abs_t'(56435);
        endcase
      end
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic wt_t gauss_wt(input int pts, input logic [1:0] i);
    wt_t w;
    w = '0;
    unique case (pts)
      2: begin
        unique case (i)
          2'd0, 2'd1: w = wt_t'(65536);
          default:    w = '0;
        endcase
      end
      3: begin
        unique case (i)
          2'd0, 2'd2: w = wt_t'(36409);
          2'd1:       w = wt_t'(58254);
          default:    w = '0;
        endcase
      end
      4: begin
        unique case (i)
          2'd0, 2'd3: w = wt_t'(22797);
          default:    w = wt_t'(42739);
        endcase
      end
      default: w = (i == 2'd0) ? wt_t'(131072) : '0;
    endcase
    return w;
  endfunction

  // 4*dN_k/dr
  function automatic grad_t grad_r(input logic [1:0] k, input abs_t sa);
    grad_t one;
    grad_t s;
    grad_t g;
    one = grad_t'(ONE_Q16);
    s   = grad_t'(sa);
    unique case (k)
      2'd0:    g = one + s;
      2'd1:    g = -(one + s);
      2'd2:    g = -(one - s);
      default: g = one - s;
    endcase
    return g;
  endfunction

  // 4*dN_k/ds
  function automatic grad_t grad_s(input logic [1:0] k, input abs_t ra);
    grad_t one;
    grad_t r;
    grad_t g;
    one = grad_t'(ONE_Q16);
    r   = grad_t'(ra);
    unique case (k)
      2'd0:    g = one + r;
      2'd1:    g = one - r;
      2'd2:    g = -(one - r);
      default: g = -(one + r);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bqsj_front.sv =====
// ---------------------------------------------------------------------------
// bqsj_front
// Per-point work: shape values, Jacobian, determinant and scaled weight.
// ---------------------------------------------------------------------------
`default_nettype none

module bqsj_front #(
  parameter int GAUSS_POINTS = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_point_index,
  input  logic signed [31:0]        in_node0_x,
  input  logic signed [31:0]        in_node0_y,
  input  logic signed [31:0]        in_node1_x,
  input  logic signed [31:0]        in_node1_y,
  input  logic signed [31:0]        in_node2_x,
  input  logic signed [31:0]        in_node2_y,
  input  logic signed [31:0]        in_node3_x,
  input  logic signed [31:0]        in_node3_y,
  input  logic                      q_full,
  output logic                      push,
  output bqsj_pkg::bqsj_item_t      push_item
);
  import bqsj_pkg::*;

  localparam int Pts = (GAUSS_POINTS < 1) ? 1 : ((GAUSS_POINTS > 4) ? 4 : GAUSS_POINTS);

  function automatic logic signed [31:0] rclamp(input logic signed [51:0] v);
    logic signed [51:0] t;
    logic signed [33:0] q;
    logic signed [31:0] r;
    t = v + 52'sd131072;
    q = 34'(t >>> 18);
    if (q > 34'sd2147483647) r = 32'sh7fffffff;
    else if (q < -34'sd2147483648) r = 32'sh80000000;
    else r = q[31:0];
    return r;
  endfunction

  logic en;
  assign en       = !q_full;
  assign in_ready = en;

  // stage 1: input capture
  logic               v1_r;
  logic [1:0]         idx_r;
  logic signed [31:0] cx_r [4];
  logic signed [31:0] cy_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r   <= in_point_index;
      cx_r[0] <= in_node0_x;
      cy_r[0] <= in_node0_y;
      cx_r[1] <= in_node1_x;
      cy_r[1] <= in_node1_y;
      cx_r[2] <= in_node2_x;
      cy_r[2] <= in_node2_y;
      cx_r[3] <= in_node3_x;
      cy_r[3] <= in_node3_y;
    end
  end

  // table lookup, gradient times coordinate products, shape values
  logic [1:0]         ri, si;
  abs_t               ra, sa;
  grad_t              gr [4];
  grad_t              gs [4];
  logic signed [49:0] mrx [4];
  logic signed [49:0] mry [4];
  logic signed [49:0] msx [4];
  logic signed [49:0] msy [4];
  logic signed [17:0] aps, ams, bps, bms;
  logic [33:0]        shp [4];
  wt_t                wr, ws;
  logic [34:0]        wprod;
  logic [18:0]        wq;
  bqsj_item_t         it2;

  always_comb begin
    ri = point_r(Pts, idx_r);
    si = point_s(Pts, idx_r);
    ra = gauss_abs(Pts, ri);
    sa = gauss_abs(Pts, si);
    for (int m = 0; m < 4; m++) begin
      gr[m]  = grad_r(2'(m), sa);
      gs[m]  = grad_s(2'(m), ra);
      mrx[m] = 50'(gr[m]) * 50'(cx_r[m]);
      mry[m] = 50'(gr[m]) * 50'(cy_r[m]);
      msx[m] = 50'(gs[m]) * 50'(cx_r[m]);
      msy[m] = 50'(gs[m]) * 50'(cy_r[m]);
    end
    aps = 18'sd65536 + 18'(ra);
    ams = 18'sd65536 - 18'(ra);
    bps = 18'sd65536 + 18'(sa);
    bms = 18'sd65536 - 18'(sa);
    shp[0] = 34'(aps[16:0]) * 34'(bps[16:0]);
    shp[1] = 34'(ams[16:0]) * 34'(bps[16:0]);
    shp[2] = 34'(ams[16:0]) * 34'(bms[16:0]);
    shp[3] = 34'(aps[16:0]) * 34'(bms[16:0]);
    wr    = gauss_wt(Pts, ri);
    ws    = gauss_wt(Pts, si);
    wprod = 35'(wr) * 35'(ws);
    wq    = 19'((wprod + 35'd32768) >> 16);
    it2    = '0;
    it2.ra = ra;
    it2.sa = sa;
    for (int k = 0; k < 4; k++) begin
      it2.shape[k] = 17'((shp[k] + 34'd131072) >> 18);
    end
  end

  // stage 2
  logic               v2_r;
  bqsj_item_t         it2_r;
  logic [18:0]        wq2_r;
  logic signed [49:0] mrx_r [4];
  logic signed [49:0] mry_r [4];
  logic signed [49:0] msx_r [4];
  logic signed [49:0] msy_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2_r <= it2;
      wq2_r <= wq;
      mrx_r <= mrx;
      mry_r <= mry;
      msx_r <= msx;
      msy_r <= msy;
    end
  end

  // Jacobian entries: sum, round half up by 2^18, saturate
  logic signed [51:0] a00, a01, a10, a11;
  bqsj_item_t         it3;

  always_comb begin
    a00 = 52'(mrx_r[0]) + 52'(mrx_r[1]) + 52'(mrx_r[2]) + 52'(mrx_r[3]);
    a01 = 52'(mry_r[0]) + 52'(mry_r[1]) + 52'(mry_r[2]) + 52'(mry_r[3]);
    a10 = 52'(msx_r[0]) + 52'(msx_r[1]) + 52'(msx_r[2]) + 52'(msx_r[3]);
    a11 = 52'(msy_r[0]) + 52'(msy_r[1]) + 52'(msy_r[2]) + 52'(msy_r[3]);
    it3     = it2_r;
    it3.j00 = rclamp(a00);
    it3.j01 = rclamp(a01);
    it3.j10 = rclamp(a10);
    it3.j11 = rclamp(a11);
  end

  // stage 3
  logic        v3_r;
  bqsj_item_t  it3_r;
  logic [18:0] wq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it3_r <= it3;
      wq3_r <= wq2_r;
    end
  end

  // stage 4: determinant products
  logic               v4_r;
  bqsj_item_t         it4_r;
  logic [18:0]        wq4_r;
  logic signed [63:0] p0_r, p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it4_r <= it3_r;
      wq4_r <= wq3_r;
      p0_r  <= 64'(it3_r.j00) * 64'(it3_r.j11);
      p1_r  <= 64'(it3_r.j10) * 64'(it3_r.j01);
    end
  end

  // determinant, sign, magnitude
  logic signed [63:0] det;
  bqsj_item_t         it5;

  always_comb begin
    det         = p0_r - p1_r;
    it5         = it4_r;
    it5.det_neg = det[63];
    it5.det_mag = det[63] ? $unsigned(-det) : $unsigned(det);
    it5.sing    = (det == 64'sd0);
  end

  // stage 5
  logic        v5_r;
  bqsj_item_t  it5_r;
  logic [18:0] wq5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it5_r <= it5;
      wq5_r <= wq4_r;
    end
  end

  // stage 6: weight times |det| as two 32-bit halves
  logic        v6_r;
  bqsj_item_t  it6_r;
  logic [50:0] hi_r, lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it6_r <= it5_r;
      hi_r  <= 51'(it5_r.det_mag[63:32]) * 51'(wq5_r);
      lo_r  <= 51'(it5_r.det_mag[31:0]) * 51'(wq5_r);
    end
  end

  // combine, round magnitude half up, saturate
  logic [51:0] res;

  always_comb begin
    res       = 52'(hi_r) + 52'((lo_r + 51'h80000000) >> 32);
    push_item = it6_r;
    if (!it6_r.det_neg) begin
      push_item.wout = (res > 52'h7fffffff) ? 32'sh7fffffff : res[31:0];
    end else begin
      push_item.wout = (res > 52'h80000000) ? 32'sh80000000 : (~res[31:0] + 32'd1);
    end
  end

  assign push = v6_r && en;

endmodule

`default_nettype wire

// ===== rtl/bqsj_fifo.sv =====
// ---------------------------------------------------------------------------
// bqsj_fifo
// Short queue of per-point records between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module bqsj_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bqsj_pkg::bqsj_item_t wr_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output bqsj_pkg::bqsj_item_t rd_item
);
  import bqsj_pkg::*;

  bqsj_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

`default_nettype wire

// ===== rtl/bqsj_back.sv =====
// ---------------------------------------------------------------------------
// bqsj_back
// Per-node work: derivative numerators, pipelined divide by detJ, output beat.
// ---------------------------------------------------------------------------
`default_nettype none

module bqsj_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  bqsj_pkg::bqsj_item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_node_index,
  output logic signed [31:0]   out_shape_value,
  output logic signed [31:0]   out_shape_dx,
  output logic signed [31:0]   out_shape_dy,
  output logic signed [31:0]   out_scaled_weight,
  output logic                 out_singular,
  output logic                 out_last
);
  import bqsj_pkg::*;

  function automatic logic [31:0] qsat(input logic big, input logic neg,
                                       input logic [31:0] q);
    logic [31:0] r;
    if (!neg) r = (big || q[31]) ? 32'h7fffffff : q;
    else r = (big || (q[31] && (|q[30:0]))) ? 32'h80000000 : (~q + 32'd1);
    return r;
  endfunction

  logic out_valid_r;
  logic en, take;
  logic [1:0] k_r;

  assign en   = !out_valid_r || out_ready;
  assign take = en && !q_empty;
  assign pop  = take && (k_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= '0;
    else if (take) k_r <= k_r + 2'd1;
  end

  // B0: node select
  logic               v0_r;
  bqsj_meta_t         meta0, meta0_r;
  grad_t              gr0_r, gs0_r;
  logic signed [31:0] j00_r, j01_r, j10_r, j11_r;
  logic [63:0]        dmag0_r;
  logic               dneg0_r;

  always_comb begin
    meta0       = '0;
    meta0.node  = k_r;
    meta0.last  = (k_r == 2'd3);
    meta0.shape = q_item.shape[k_r];
    meta0.wout  = q_item.wout;
    meta0.sing  = q_item.sing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= take;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta0_r <= meta0;
      gr0_r   <= grad_r(k_r, q_item.sa);
      gs0_r   <= grad_s(k_r, q_item.ra);
      j00_r   <= q_item.j00;
      j01_r   <= q_item.j01;
      j10_r   <= q_item.j10;
      j11_r   <= q_item.j11;
      dmag0_r <= q_item.det_mag;
      dneg0_r <= q_item.det_neg;
    end
  end

  // B1: numerator products
  logic               v1_r;
  bqsj_meta_t         meta1_r;
  logic signed [49:0] pa_r, pb_r, pc_r, pd_r;
  logic [63:0]        dmag1_r;
  logic               dneg1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1_r <= meta0_r;
      pa_r    <= 50'(j11_r) * 50'(gr0_r);
      pb_r    <= 50'(j01_r) * 50'(gs0_r);
      pc_r    <= 50'(j00_r) * 50'(gs0_r);
      pd_r    <= 50'(j10_r) * 50'(gr0_r);
      dmag1_r <= dmag0_r;
      dneg1_r <= dneg0_r;
    end
  end

  // numerators times 2^14 as sign and magnitude
  logic signed [50:0] nx, ny;
  logic [50:0]        nxm, nym;
  bqsj_meta_t         meta_d0;

  always_comb begin
    nx            = 51'(pa_r) - 51'(pb_r);
    ny            = 51'(pc_r) - 51'(pd_r);
    nxm           = nx[50] ? $unsigned(-nx) : $unsigned(nx);
    nym           = ny[50] ? $unsigned(-ny) : $unsigned(ny);
    meta_d0       = meta1_r;
    meta_d0.neg_x = nx[50] ^ dneg1_r;
    meta_d0.neg_y = ny[50] ^ dneg1_r;
  end

  // divider pipeline: stage 0 holds operands, stage s resolves quotient bit QBITS-s
  logic              dv_r   [QBITS+1];
  bqsj_meta_t        meta_r [QBITS+1];
  logic [63:0]       dd_r   [QBITS+1];
  logic [63:0]       rx_r   [QBITS+1];
  logic [63:0]       ry_r   [QBITS+1];
  logic [QBITS-1:0]  qx_r   [QBITS+1];
  logic [QBITS-1:0]  qy_r   [QBITS+1];
  logic              bigx_r [QBITS+1];
  logic              bigy_r [QBITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (en) dv_r[0] <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= meta_d0;
      dd_r[0]   <= dmag1_r;
      rx_r[0]   <= {1'b0, nxm[48:0], 14'b0};
      ry_r[0]   <= {1'b0, nym[48:0], 14'b0};
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      bigx_r[0] <= 1'b0;
      bigy_r[0] <= 1'b0;
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_div
    localparam int B = QBITS - s;
    logic [95:0] dsh;
    logic        gex, gey, bx, by;

    always_comb begin
      dsh = 96'(dd_r[s-1]) << B;
      gex = (96'(rx_r[s-1]) >= dsh);
      gey = (96'(ry_r[s-1]) >= dsh);
      if (s == 1) begin
        // quotient of 2^32 or more saturates regardless of low bits
        bx = (96'(rx_r[s-1]) >= {dd_r[s-1], 32'b0});
        by = (96'(ry_r[s-1]) >= {dd_r[s-1], 32'b0});
      end else begin
        bx = bigx_r[s-1];
        by = bigy_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[s] <= 1'b0;
      else if (en) dv_r[s] <= dv_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[s] <= meta_r[s-1];
        dd_r[s]   <= dd_r[s-1];
        rx_r[s]   <= gex ? (rx_r[s-1] - dsh[63:0]) : rx_r[s-1];
        ry_r[s]   <= gey ? (ry_r[s-1] - dsh[63:0]) : ry_r[s-1];
        qx_r[s]   <= qx_r[s-1] | (gex ? (QBITS'(1) << B) : '0);
        qy_r[s]   <= qy_r[s-1] | (gey ? (QBITS'(1) << B) : '0);
        bigx_r[s] <= bx;
        bigy_r[s] <= by;
      end
    end
  end

  // output register
  bqsj_meta_t  mo;
  logic [31:0] dx_nxt, dy_nxt;
  logic [1:0]  node_r;
  shape_t      shape_r;
  logic [31:0] dx_r, dy_r, wout_r;
  logic        sing_r, last_r;

  always_comb begin
    mo     = meta_r[QBITS];
    dx_nxt = mo.sing ? 32'd0 : qsat(bigx_r[QBITS], mo.neg_x, qx_r[QBITS]);
    dy_nxt = mo.sing ? 32'd0 : qsat(bigy_r[QBITS], mo.neg_y, qy_r[QBITS]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_r[QBITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      node_r  <= mo.node;
      shape_r <= mo.shape;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      wout_r  <= mo.wout;
      sing_r  <= mo.sing;
      last_r  <= mo.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_node_index    = node_r;
  assign out_shape_value   = 32'(shape_r);
  assign out_shape_dx      = dx_r;
  assign out_shape_dy      = dy_r;
  assign out_scaled_weight = wout_r;
  assign out_singular      = sing_r;
  assign out_last          = last_r;

endmodule

`default_nettype wire

// ===== rtl/bilinear_quad_shape_jacobian.sv =====
// ---------------------------------------------------------------------------
// bilinear_quad_shape_jacobian
// Q4 isoparametric shape functions, Jacobian and global derivatives.
// Throughput: set by the back end's single divider pipeline, one node result
//   (two 32-step quotients) per cycle unless stalled; four per input beat.
// Reset: synchronous active-low rst_n empties the queue and all valid flags;
//   no clearing pass, in_ready is high as soon as the queue count is cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module bilinear_quad_shape_jacobian #(
  parameter int GAUSS_POINTS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel: one beat per Gauss point
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_point_index,
  input  logic signed [31:0] in_node0_x,
  input  logic signed [31:0] in_node0_y,
  input  logic signed [31:0] in_node1_x,
  input  logic signed [31:0] in_node1_y,
  input  logic signed [31:0] in_node2_x,
  input  logic signed [31:0] in_node2_y,
  input  logic signed [31:0] in_node3_x,
  input  logic signed [31:0] in_node3_y,
  // result channel: four beats per input, node order 0..3
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_node_index,
  output logic signed [31:0] out_shape_value,
  output logic signed [31:0] out_shape_dx,
  output logic signed [31:0] out_shape_dy,
  output logic signed [31:0] out_scaled_weight,
  output logic               out_singular,
  output logic               out_last
);
  import bqsj_pkg::*;

  // Front end: table lookup, shape values, Jacobian, detJ and w*detJ,
  // six register stages, stalls only when the queue is full.
  // Queue: QDEPTH point records, lets the front run ahead of the back.
  // Back end: walks the head record's four nodes, one per cycle unless stalled,
  // via numerator multiply, bit-per-stage restoring divide and output register.

  logic       q_full, q_empty, q_push, q_pop;
  bqsj_item_t q_wr, q_rd;

  bqsj_front #(
    .GAUSS_POINTS (GAUSS_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_index (in_point_index),
    .in_node0_x     (in_node0_x),
    .in_node0_y     (in_node0_y),
    .in_node1_x     (in_node1_x),
    .in_node1_y     (in_node1_y),
    .in_node2_x     (in_node2_x),
    .in_node2_y     (in_node2_y),
    .in_node3_x     (in_node3_x),
    .in_node3_y     (in_node3_y),
    .q_full         (q_full),
    .push           (q_push),
    .push_item      (q_wr)
  );

  bqsj_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd)
  );

  bqsj_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (q_rd),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_node_index    (out_node_index),
    .out_shape_value   (out_shape_value),
    .out_shape_dx      (out_shape_dx),
    .out_shape_dy      (out_shape_dy),
    .out_scaled_weight (out_scaled_weight),
    .out_singular      (out_singular),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/bqsj_checker.sv =====
// ---------------------------------------------------------------------------
// bqsj_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bilinear_quad_shape_jacobian_defines.svh"

module bqsj_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_node_index,
  input logic signed [31:0] out_shape_dx,
  input logic signed [31:0] out_shape_dy,
  input logic signed [31:0] out_scaled_weight,
  input logic               out_singular,
  input logic               out_last
);

  // stalled beat holds
  `BQSJ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_shape_dx) && $stable(out_shape_dy) && $stable(out_node_index), "out beat changed while stalled")

  // last flag marks node 3 only
  `BQSJ_ASSERT(a_last_node, out_valid |-> (out_last == (out_node_index == 2'd3)), "last flag not on node 3")

  // nodes of one point leave back to back
  `BQSJ_ASSERT(a_node_seq, out_valid && out_ready && !out_last |=> out_valid && (out_node_index == $past(out_node_index) + 2'd1), "node sequence broken")

  // zero determinant clears derivatives and weight
  `BQSJ_ASSERT(a_singular, out_valid && out_singular |-> out_shape_dx == 0 && out_shape_dy == 0 && out_scaled_weight == 0, "singular beat carries nonzero values")

  // nothing valid coming out of reset
  `BQSJ_ASSERT_RST(a_reset, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

bind bilinear_quad_shape_jacobian bqsj_checker u_bqsj_checker (.*);

`default_nettype wire
